/* rtl/hmv_pkg.sv */
`default_nettype none

package hmv_pkg;

    // Fixed field widths.
    localparam int AZ_W     = 17;
    localparam int EL_W     = 16;
    localparam int QAZ_W    = 32;
    localparam int IDX_W    = 6;
    localparam int NUM_W    = 7;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_ANGLE_BITS = 16;

    localparam logic [NUM_W-1:0] RESET_NUM_POINTS = 7'd2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_OVERRUN   = 2'd1;
    localparam status_t STATUS_BAD_INDEX = 2'd2;

    typedef logic op_t;

    localparam op_t OP_LOAD  = 1'b0;
    localparam op_t OP_QUERY = 1'b1;

    typedef struct packed {
        op_t                     op;
        logic [IDX_W-1:0]        entry_index;
        logic [AZ_W-1:0]         entry_azimuth;
        logic signed [EL_W-1:0]  entry_elevation;
        logic signed [QAZ_W-1:0] query_azimuth;
        logic signed [EL_W-1:0]  query_elevation;
    } req_t;

    typedef struct packed {
        logic                   is_visible;
        logic signed [EL_W-1:0] mask_elevation;
        status_t                status;
    } rsp_t;

    typedef logic [NUM_W-1:0] cfg_t;

endpackage

`default_nettype wire

/* rtl/hmv_chan_if.sv */
`default_nettype none

interface hmv_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/horizon_mask_visibility.sv */
`default_nettype none

// Channel  Dir  Payload               Meaning
// req      in   hmv_pkg::req_t        breakpoint load or visibility query
// rsp      out  hmv_pkg::rsp_t        one result per request
// cfg      in   hmv_pkg::cfg_t        num_points register write
//
// A load goes straight to its result. A query primes the search, scans k
// breakpoints (one read of the breakpoint memory per cycle), multiplies,
// prepares and runs the bit-serial divider, which yields P = max(ANGLE_BITS,
// 17) + 18 quotient bits (35 with the default parameters). A zero-width
// segment skips the divider and a search overrun ends after the scan.
// One request is in work at a time.
// Reset clears the control state and sets num_points to 2; the breakpoint
// memory is not cleared. A finished result waits in the output register while
// the next request is already taken; the block stalls only when a new result
// is ready and the previous one has not been transferred yet.

module horizon_mask_visibility #(
    parameter int MAX_POINTS = hmv_pkg::DEF_MAX_POINTS,
    parameter int ANGLE_BITS = hmv_pkg::DEF_ANGLE_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hmv_chan_if.sink   req,
    hmv_chan_if.source rsp,
    hmv_chan_if.sink   cfg
);

    localparam int AZ_W   = hmv_pkg::AZ_W;
    localparam int EL_W   = hmv_pkg::EL_W;
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CW     = AW + 1;
    localparam int UW     = (ANGLE_BITS > AZ_W) ? ANGLE_BITS : AZ_W;
    localparam int DW     = UW + 1;
    localparam int SW     = AZ_W + 1;
    localparam int DIFF_W = EL_W + 1;
    localparam int PW     = DW + DIFF_W;
    localparam int SUM_W  = PW + 2;
    localparam int DCW    = $clog2(PW);
    localparam int MW     = AZ_W + EL_W;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_SCAN,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [hmv_pkg::NUM_W-1:0] num_points_reg;
    logic [ANGLE_BITS-1:0]   az_reg;
    logic signed [EL_W-1:0]  qel_reg;
    logic [CW-1:0]           count_reg;
    logic [AW-1:0]           cur_reg;
    logic [AZ_W-1:0]         b_az_reg;
    logic signed [EL_W-1:0]  b_el_reg;
    logic [AZ_W-1:0]         e_az_reg;
    logic signed [EL_W-1:0]  e_el_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [SW-1:0]    span_reg;
    logic                    neg_reg;
    logic [PW-1:0]           num_reg;
    logic [AZ_W-1:0]         den_reg;
    logic [AZ_W-1:0]         rem_reg;
    logic [DCW-1:0]          div_cnt_reg;
    hmv_pkg::rsp_t           res_reg;
    hmv_pkg::rsp_t           out_data_reg;
    logic                    out_valid_reg;
    logic [MW-1:0]           rd_data_reg;

    logic [MW-1:0] bp_mem [MAX_POINTS];

    logic                   req_xfer;
    logic                   idx_ok;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [AZ_W-1:0]        rd_az;
    logic signed [EL_W-1:0] rd_el;
    logic [CW-1:0]          count_clamp;
    logic [CW-1:0]          cur_next_cnt;
    logic [UW-1:0]          az_u;
    logic [UW-1:0]          rd_az_u;
    logic [UW-1:0]          b_az_u;
    logic signed [DIFF_W-1:0] diff_w;
    logic signed [DW-1:0]   delta_w;
    logic signed [SW-1:0]   span_w;
    logic signed [PW-1:0]   prod_w;
    logic [PW-1:0]          prod_mag;
    logic [SW-1:0]          span_mag;
    logic [AZ_W:0]          div_shift;
    logic                   div_ge;
    logic [AZ_W-1:0]        div_rem;
    logic signed [SUM_W-1:0] quo_s;
    logic signed [SUM_W-1:0] sum_w;
    logic signed [EL_W-1:0] mask_sat;
    logic                   slot_free;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign req_xfer  = req.valid && req.ready;
    assign idx_ok    = 32'(req.data.entry_index) < 32'(MAX_POINTS);
    assign wr_en     = req_xfer && (req.data.op == hmv_pkg::OP_LOAD) && idx_ok;
    assign wr_addr   = AW'(req.data.entry_index);
    assign slot_free = !out_valid_reg || rsp.ready;

    assign rd_az = rd_data_reg[MW-1:EL_W];
    assign rd_el = signed'(rd_data_reg[EL_W-1:0]);

    assign cur_next_cnt = CW'(cur_reg) + CW'(1);

    always_comb
    begin
        if (32'(num_points_reg) > 32'(MAX_POINTS))
            count_clamp = CW'(MAX_POINTS);
        else if (num_points_reg < hmv_pkg::NUM_W'(2))
            count_clamp = CW'(2);
        else
            count_clamp = CW'(num_points_reg);
    end

    // The search streams one entry per cycle: the read of the next entry is
    // issued while the current one is compared.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                rd_en   = req_xfer && (req.data.op == hmv_pkg::OP_QUERY);
                rd_addr = '0;
            end
            ST_PRIME:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(1);
            end
            ST_SCAN:
            begin
                rd_en   = cur_next_cnt < count_reg;
                rd_addr = cur_next_cnt[AW-1:0];
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            bp_mem[wr_addr] <= {req.data.entry_azimuth, req.data.entry_elevation};
        if (rd_en)
            rd_data_reg <= bp_mem[rd_addr];
    end

    assign az_u    = UW'(az_reg);
    assign rd_az_u = UW'(rd_az);
    assign b_az_u  = UW'(b_az_reg);

    assign diff_w  = DIFF_W'(e_el_reg) - DIFF_W'(b_el_reg);
    assign delta_w = signed'({1'b0, az_u}) - signed'({1'b0, b_az_u});
    assign span_w  = signed'({1'b0, e_az_reg}) - signed'({1'b0, b_az_reg});
    assign prod_w  = diff_w * delta_w;

    assign prod_mag = prod_reg[PW-1] ? unsigned'(-prod_reg) : unsigned'(prod_reg);
    assign span_mag = span_reg[SW-1] ? unsigned'(-span_reg) : unsigned'(span_reg);

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of num_reg at the top while quotient bits shift in at the bottom.
    assign div_shift = {rem_reg, num_reg[PW-1]};
    assign div_ge    = div_shift >= {1'b0, den_reg};
    assign div_rem   = div_ge ? AZ_W'(div_shift - {1'b0, den_reg}) : div_shift[AZ_W-1:0];

    assign quo_s = neg_reg ? -signed'({2'b00, num_reg}) : signed'({2'b00, num_reg});
    assign sum_w = SUM_W'(b_el_reg) + quo_s;

    always_comb
    begin
        if (sum_w > SAT_HI)
            mask_sat = 16'sh7FFF;
        else if (sum_w < SAT_LO)
            mask_sat = 16'sh8000;
        else
            mask_sat = sum_w[EL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_points_reg <= hmv_pkg::RESET_NUM_POINTS;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            res_reg        <= '0;
            az_reg         <= '0;
            qel_reg        <= '0;
            count_reg      <= '0;
            cur_reg        <= '0;
            b_az_reg       <= '0;
            b_el_reg       <= '0;
            e_az_reg       <= '0;
            e_el_reg       <= '0;
            prod_reg       <= '0;
            span_reg       <= '0;
            neg_reg        <= 1'b0;
            num_reg        <= '0;
            den_reg        <= '0;
            rem_reg        <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
                num_points_reg <= cfg.data;

            if (state_reg == ST_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_reg;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (req.data.op == hmv_pkg::OP_LOAD)
                        begin
                            res_reg.is_visible     <= 1'b0;
                            res_reg.mask_elevation <= '0;
                            res_reg.status         <= idx_ok ? hmv_pkg::STATUS_OK
                                                             : hmv_pkg::STATUS_BAD_INDEX;
                            state_reg              <= ST_DONE;
                        end
                        else
                        begin
                            az_reg    <= req.data.query_azimuth[ANGLE_BITS-1:0];
                            qel_reg   <= req.data.query_elevation;
                            count_reg <= count_clamp;
                            state_reg <= ST_PRIME;
                        end
                    end
                end
                ST_PRIME:
                begin
                    b_az_reg  <= rd_az;
                    b_el_reg  <= rd_el;
                    cur_reg   <= AW'(1);
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (az_u > rd_az_u)
                    begin
                        if (cur_next_cnt >= count_reg)
                        begin
                            res_reg.is_visible     <= 1'b0;
                            res_reg.mask_elevation <= '0;
                            res_reg.status         <= hmv_pkg::STATUS_OVERRUN;
                            state_reg              <= ST_DONE;
                        end
                        else
                        begin
                            b_az_reg <= rd_az;
                            b_el_reg <= rd_el;
                            cur_reg  <= cur_next_cnt[AW-1:0];
                        end
                    end
                    else
                    begin
                        e_az_reg  <= rd_az;
                        e_el_reg  <= rd_el;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= prod_w;
                    span_reg  <= span_w;
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    neg_reg     <= prod_reg[PW-1] ^ span_reg[SW-1];
                    den_reg     <= span_mag[AZ_W-1:0];
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    // A zero-width segment takes the elevation of the earlier breakpoint as is.
                    if (span_reg == '0)
                    begin
                        num_reg   <= '0;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        num_reg   <= prod_mag;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg     <= div_rem;
                    num_reg     <= {num_reg[PW-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                    if (div_cnt_reg == DCW'(PW - 1))
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    res_reg.is_visible     <= qel_reg >= mask_sat;
                    res_reg.mask_elevation <= mask_sat;
                    res_reg.status         <= hmv_pkg::STATUS_OK;
                    state_reg              <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (slot_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> CW'(cur_reg) < count_reg)
        else $error("search index reached the breakpoint count");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> den_reg != '0)
        else $error("divider started with a zero span");

    a_overrun_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.status == hmv_pkg::STATUS_OVERRUN
            |-> !rsp.data.is_visible && rsp.data.mask_elevation == '0)
        else $error("overrun result carries a mask value");

    a_rsp_drains: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ready && state_reg != ST_DONE |=> !rsp.valid)
        else $error("result repeated after its transfer");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS = hmv_pkg::DEF_MAX_POINTS;
    localparam int ANG_W = hmv_pkg::DEF_ANGLE_BITS;
    localparam int AZ_W = hmv_pkg::AZ_W;
    localparam int EL_W = hmv_pkg::EL_W;
    localparam int IDX_W = hmv_pkg::IDX_W;
    localparam int IDLE_PCT = 21;
    localparam int DRAIN_CYCLES = 150;
    localparam hmv_pkg::rsp_t LOAD_DONE = '{is_visible: 1'b0, mask_elevation: '0,
                                           status: hmv_pkg::STATUS_OK};

    typedef struct {
        hmv_pkg::req_t item;
        bit            typed;
        hmv_pkg::rsp_t result;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    hmv_chan_if #(.payload_t(hmv_pkg::req_t)) req_if ();
    hmv_chan_if #(.payload_t(hmv_pkg::rsp_t)) rsp_if ();
    hmv_chan_if #(.payload_t(hmv_pkg::cfg_t)) cfg_if ();

    horizon_mask_visibility u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Shadow copy of the breakpoint table and the count register.
    bit [AZ_W-1:0]          bp_az [MAX_PTS];
    logic signed [EL_W-1:0] bp_el [MAX_PTS];
    hmv_pkg::cfg_t          num_points_reg = hmv_pkg::RESET_NUM_POINTS;

    hmv_pkg::rsp_t pending_visibility [$];
    int   mismatches = 0;
    int   items_sent = 0;
    bit   quiet = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic hmv_pkg::rsp_t outcome(bit vis, int mask, hmv_pkg::status_t st);
        hmv_pkg::rsp_t o;
        o.is_visible     = vis;
        o.mask_elevation = mask[EL_W-1:0];
        o.status         = st;
        return o;
    endfunction

    function automatic hmv_pkg::req_t load_item(int idx, int az, int el);
        hmv_pkg::req_t r = '0;
        r.op              = hmv_pkg::OP_LOAD;
        r.entry_index     = idx[IDX_W-1:0];
        r.entry_azimuth   = az[AZ_W-1:0];
        r.entry_elevation = el[EL_W-1:0];
        return r;
    endfunction

    function automatic hmv_pkg::req_t query_item(int az, int el);
        hmv_pkg::req_t r = '0;
        r.op              = hmv_pkg::OP_QUERY;
        r.query_azimuth   = az;
        r.query_elevation = el[EL_W-1:0];
        return r;
    endfunction

    // Applies a load to the shadow table, or works out the interpolated mask for a query.
    function automatic hmv_pkg::rsp_t mask_lookup(hmv_pkg::req_t r);
        int unsigned   cnt;
        int unsigned   i;
        bit [ANG_W-1:0] az;
        longint        span;
        longint        delta;
        longint        elb;
        longint        ele;
        longint        mask;
        if (r.op == hmv_pkg::OP_LOAD)
        begin
            if (int'(r.entry_index) >= MAX_PTS)
                return outcome(1'b0, 0, hmv_pkg::STATUS_BAD_INDEX);
            bp_az[r.entry_index] = r.entry_azimuth;
            bp_el[r.entry_index] = r.entry_elevation;
            return outcome(1'b0, 0, hmv_pkg::STATUS_OK);
        end
        cnt = num_points_reg;
        if (cnt < 2)
            cnt = 2;
        if (cnt > MAX_PTS)
            cnt = MAX_PTS;
        az = r.query_azimuth[ANG_W-1:0];
        i = 1;
        while (i < cnt && az > bp_az[i])
            i++;
        if (i >= cnt)
            return outcome(1'b0, 0, hmv_pkg::STATUS_OVERRUN);
        elb   = bp_el[i-1];
        ele   = bp_el[i];
        span  = longint'(bp_az[i]) - longint'(bp_az[i-1]);
        delta = longint'(az) - longint'(bp_az[i-1]);
        mask  = elb;
        // Division in SystemVerilog truncates toward zero, as the block does.
        if (span != 0)
            mask = elb + (ele - elb) * delta / span;
        if (mask > 32767)
            mask = 32767;
        if (mask < -32768)
            mask = -32768;
        return outcome(longint'(r.query_elevation) >= mask, int'(mask), hmv_pkg::STATUS_OK);
    endfunction

    function automatic int random_elevation();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic hmv_pkg::req_t random_query(int unsigned c);
        int            ext [6] = '{0, -1, 32'h7FFF_FFFF, 32'h8000_0000, 65535, 65536};
        int            qa;
        int            lo;
        hmv_pkg::req_t q;
        hmv_pkg::rsp_t trial;
        case ($urandom_range(0, 3))
            0: qa = $urandom();
            1:
            begin
                lo = int'(bp_az[$urandom_range(0, c - 1)]) + int'($urandom_range(0, 4)) - 2;
                qa = ($urandom() & 32'hFFFF_0000) | (lo & 32'h0000_FFFF);
            end
            2: qa = ext[$urandom_range(0, 5)];
            default: qa = $urandom_range(0, 65535);
        endcase
        q = query_item(qa, random_elevation());
        // Aim a third of the queries that find an in-range mask right at the visibility threshold.
        trial = mask_lookup(q);
        if (trial.status == hmv_pkg::STATUS_OK && $urandom_range(0, 2) == 0
            && trial.mask_elevation > -16384 && trial.mask_elevation <= 16384)
            q.query_elevation = trial.mask_elevation - EL_W'($urandom_range(0, 1));
        return q;
    endfunction

    task automatic send_item(hmv_pkg::req_t r, bit typed, hmv_pkg::rsp_t typed_result);
        hmv_pkg::rsp_t predicted;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predicted = mask_lookup(r);
        pending_visibility = {pending_visibility, (typed ? typed_result : predicted)};
        items_sent++;
    endtask

    task automatic write_num_points(hmv_pkg::cfg_t v);
        while (pending_visibility.size() != 0)
            @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid   <= 1'b0;
        num_points_reg = v;
    endtask

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        hmv_pkg::rsp_t want;
        if (rsp_if.valid && rsp_if.ready)
        begin
            if (pending_visibility.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: vis=%0b mask=%0d status=%0d",
                             rsp_if.data.is_visible, rsp_if.data.mask_elevation,
                             rsp_if.data.status);
            end
            else
            begin
                want = pending_visibility.pop_front();
                if (rsp_if.data.is_visible !== want.is_visible
                    || rsp_if.data.mask_elevation !== want.mask_elevation
                    || rsp_if.data.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"wrong result: expected vis=%0b mask=%0d status=%0d,",
                                  " got vis=%0b mask=%0d status=%0d"},
                                 want.is_visible, want.mask_elevation, want.status,
                                 rsp_if.data.is_visible, rsp_if.data.mask_elevation,
                                 rsp_if.data.status);
                end
            end
        end
    end

    initial
    begin
        dir_row_t      dir_table [$];
        hmv_pkg::cfg_t raw_list [8] = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd1, 7'd65, 7'd17, 7'd64};
        hmv_pkg::cfg_t raw;
        int unsigned   c;
        int unsigned   a;
        int unsigned   step_max;
        int unsigned   n_items;
        bit            full_cover;
        int            phase;

        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the count left at its reset value of two.
        dir_table = '{
            '{load_item(0, 0, -16384),      1'b1, LOAD_DONE},
            '{load_item(1, 65536, 16384),   1'b1, LOAD_DONE},
            '{query_item(0, -16384),        1'b1, outcome(1'b1, -16384, hmv_pkg::STATUS_OK)},
            '{query_item(-1, 16384),        1'b0, '0},
            '{query_item(32'h7FFF_FFFF, 16382), 1'b0, '0},
            '{query_item(32'h8000_0000, -16384), 1'b0, '0},
            '{query_item(32768, 0),         1'b0, '0},
            '{load_item(1, 100, 50),        1'b1, LOAD_DONE},
            '{query_item(200, 0),           1'b1, outcome(1'b0, 0, hmv_pkg::STATUS_OVERRUN)},
            '{query_item(100, 50),          1'b0, '0},
            // Negative slope: the quotient truncates toward zero.
            '{load_item(0, 0, 10),          1'b1, LOAD_DONE},
            '{load_item(1, 3, 0),           1'b1, LOAD_DONE},
            '{query_item(1, 6),             1'b1, outcome(1'b0, 7, hmv_pkg::STATUS_OK)},
            // Zero-width segment takes the lower elevation.
            '{load_item(0, 5, -7),          1'b1, LOAD_DONE},
            '{load_item(1, 5, 99),          1'b1, LOAD_DONE},
            '{query_item(5, -7),            1'b1, outcome(1'b1, -7, hmv_pkg::STATUS_OK)},
            // Unsorted table: signed delta and span.
            '{load_item(0, 1000, 100),      1'b1, LOAD_DONE},
            '{load_item(1, 500, -100),      1'b1, LOAD_DONE},
            '{query_item(200, -220),        1'b0, '0},
            // Steep unsorted segments saturate the mask both ways.
            '{load_item(0, 65536, -16384),  1'b1, LOAD_DONE},
            '{load_item(1, 65535, 16384),   1'b1, LOAD_DONE},
            '{query_item(0, 16384),         1'b1, outcome(1'b0, 32767, hmv_pkg::STATUS_OK)},
            '{load_item(0, 65536, 16384),   1'b1, LOAD_DONE},
            '{load_item(1, 65535, -16384),  1'b1, LOAD_DONE},
            '{query_item(-65536, -16384),   1'b1, outcome(1'b1, -32768, hmv_pkg::STATUS_OK)}
        };
        foreach (dir_table[k])
            send_item(dir_table[k].item, dir_table[k].typed, dir_table[k].result);
        req_if.valid <= 1'b0;

        // Each phase sets the count, loads an ascending table, then queries it
        // with a sprinkling of stray loads that break the ordering.
        items_sent = 0;
        phase      = 0;
        while (items_sent < 1550)
        begin
            raw = (phase < 8) ? raw_list[phase] : hmv_pkg::cfg_t'($urandom_range(2, 64));
            write_num_points(raw);
            quiet = (phase == 3);
            c = (raw < 2) ? 2 : ((raw > MAX_PTS) ? MAX_PTS : raw);

            full_cover = ($urandom_range(0, 3) != 0);
            step_max   = 2 * 65536 / c;
            a          = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) : 0;
            for (int k = 0; k < c; k++)
            begin
                if (k > 0)
                    a += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, step_max);
                if (a > 65536 || (k == c - 1 && full_cover))
                    a = 65536;
                send_item(load_item(k, a, random_elevation()), 1'b0, '0);
            end

            n_items = $urandom_range(60, 120);
            for (int k = 0; k < n_items; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_item(load_item($urandom_range(0, MAX_PTS - 1),
                                        $urandom_range(0, 65536), random_elevation()),
                              1'b0, '0);
                else
                    send_item(random_query(c), 1'b0, '0);
            end
            req_if.valid <= 1'b0;
            phase++;
        end
        quiet = 1'b0;

        while (pending_visibility.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("horizon_mask_visibility: match");
        else
            $display("horizon_mask_visibility: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("horizon_mask_visibility: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/hmv_pkg.sv
rtl/hmv_chan_if.sv
rtl/horizon_mask_visibility.sv
bench/testbench.sv
